// File: design/ttoi_pkg.sv
`default_nettype none

package ttoi_pkg;

   localparam int TIME_W   = 24;
   localparam int AMP_W    = 16;
   localparam int WIN_W    = 10;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // differences carry one extra sign bit
   localparam int DAMP_W  = AMP_W + 1;
   localparam int DTIME_W = TIME_W + 1;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_RISE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FALL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END   = 2'd2;

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_RISE,
      JOB_FALL
   } job_kind_type;

   typedef struct packed {
      job_kind_type                kind;
      logic                        last;
      logic [STATUS_W-1:0]         status;
      logic [TIME_W-1:0]           t0;
      logic signed [DAMP_W-1:0]    num;
      logic signed [DAMP_W-1:0]    den;
      logic signed [DTIME_W-1:0]   dt;
   } job_type;

   typedef struct packed {
      logic                done;
      logic [TIME_W-1:0]   value;
   } rise_fb_type;

   typedef struct packed {
      logic [TIME_W-1:0]   rise_time;
      logic [TIME_W-1:0]   fall_time;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

`default_nettype wire

// File: design/ttoi_fifo.sv
`default_nettype none

module ttoi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  fifo_full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  fifo_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr;
   logic             do_rd;

   assign fifo_full  = (count_ff == FULL_CNT);
   assign fifo_empty = (count_ff == '0);
   assign do_wr      = wr_en && !fifo_full;
   assign do_rd      = rd_en && !fifo_empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: design/ttoi_front.sv
`default_nettype none

module ttoi_front #(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ttoi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ttoi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [ttoi_pkg::TIME_W-1:0]         req_sample_time,
   input  wire logic signed [ttoi_pkg::AMP_W-1:0]   req_sample_amplitude,
   input  wire logic                                req_last_sample,
   output logic                                     job_push,
   output ttoi_pkg::job_type                        job,
   input  wire logic                                job_full,
   input  wire ttoi_pkg::rise_fb_type               rise_fb
);

   localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W = (IDX_W > ttoi_pkg::WIN_W + 1) ? IDX_W : ttoi_pkg::WIN_W + 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SAMPLES);

   typedef enum logic [1:0] {
      PH_RISE,
      PH_FALL,
      PH_DONE
   } phase_type;

   logic signed [ttoi_pkg::AMP_W-1:0]  threshold_ff;
   logic [ttoi_pkg::WIN_W-1:0]         window_start_ff;
   logic [ttoi_pkg::WIN_W-1:0]         window_end_ff;

   logic [ttoi_pkg::TIME_W-1:0]        prev_time_ff;
   logic signed [ttoi_pkg::AMP_W-1:0]  prev_amplitude_ff;
   logic [IDX_W-1:0]                   sample_index_ff;
   phase_type                          phase_ff;
   phase_type                          phase_in;
   logic                               rise_pending_ff;
   logic [ttoi_pkg::TIME_W-1:0]        rise_value_ff;

   logic             accept;
   logic             in_window;
   logic             rise_hit;
   logic             fall_hit;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] start_ext;
   logic [CMP_W-1:0] end_ext;
   logic [ttoi_pkg::STATUS_W-1:0] status_in;

   // the fall test compares against the rise time, so wait for it
   assign full   = job_full || (rise_pending_ff && (phase_ff != PH_DONE));
   assign accept = push && !full;

   assign idx_ext   = CMP_W'(sample_index_ff);
   assign start_ext = CMP_W'(window_start_ff) + CMP_W'(1);
   assign end_ext   = CMP_W'(window_end_ff);

   assign in_window = (sample_index_ff != '0) && (idx_ext >= start_ext) &&
                      (idx_ext <= end_ext) && (sample_index_ff < MAX_IDX);

   assign rise_hit = in_window && (phase_ff == PH_RISE) &&
                     (prev_amplitude_ff < threshold_ff) &&
                     (req_sample_amplitude >= threshold_ff);

   assign fall_hit = in_window && (phase_ff == PH_FALL) &&
                     (req_sample_time > rise_value_ff) &&
                     (prev_amplitude_ff >= threshold_ff) &&
                     (req_sample_amplitude < threshold_ff);

   always_comb begin
      phase_in = phase_ff;
      if (rise_hit) begin
         phase_in = PH_FALL;
      end else if (fall_hit) begin
         phase_in = PH_DONE;
      end
      unique case (phase_in)
         PH_DONE: status_in = ttoi_pkg::STATUS_FOUND;
         PH_FALL: status_in = ttoi_pkg::STATUS_NO_FALL;
         default: status_in = ttoi_pkg::STATUS_NO_RISE;
      endcase
   end

   assign job_push = accept && (rise_hit || fall_hit || req_last_sample);

   always_comb begin
      job.kind   = rise_hit ? ttoi_pkg::JOB_RISE :
                   (fall_hit ? ttoi_pkg::JOB_FALL : ttoi_pkg::JOB_NONE);
      job.last   = req_last_sample;
      job.status = status_in;
      job.t0     = prev_time_ff;
      job.num    = ttoi_pkg::DAMP_W'(threshold_ff) - ttoi_pkg::DAMP_W'(prev_amplitude_ff);
      job.den    = ttoi_pkg::DAMP_W'(req_sample_amplitude) -
                   ttoi_pkg::DAMP_W'(prev_amplitude_ff);
      job.dt     = $signed({1'b0, req_sample_time}) - $signed({1'b0, prev_time_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         window_start_ff <= '0;
         window_end_ff   <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ttoi_pkg::CSR_THRESHOLD:    threshold_ff    <= csr_wdata;
            ttoi_pkg::CSR_WINDOW_START: window_start_ff <= csr_wdata[ttoi_pkg::WIN_W-1:0];
            ttoi_pkg::CSR_WINDOW_END:   window_end_ff   <= csr_wdata[ttoi_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rise_fb.done) begin
         rise_value_ff <= rise_fb.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff      <= '0;
         prev_amplitude_ff <= '0;
         sample_index_ff   <= '0;
         phase_ff          <= PH_RISE;
         rise_pending_ff   <= 1'b0;
      end else begin
         if (rise_fb.done) begin
            rise_pending_ff <= 1'b0;
         end
         if (accept) begin
            if (rise_hit) begin
               rise_pending_ff <= 1'b1;
            end
            if (req_last_sample) begin
               prev_time_ff      <= '0;
               prev_amplitude_ff <= '0;
               sample_index_ff   <= '0;
               phase_ff          <= PH_RISE;
            end else begin
               prev_time_ff      <= req_sample_time;
               prev_amplitude_ff <= req_sample_amplitude;
               phase_ff          <= phase_in;
               if (sample_index_ff < MAX_IDX) begin
                  sample_index_ff <= sample_index_ff + 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: design/ttoi_back.sv
`default_nettype none

module ttoi_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ttoi_pkg::job_type       job,
   input  wire logic                    job_empty,
   output logic                         job_pop,
   output ttoi_pkg::rise_fb_type        rise_fb,
   output logic                         res_push,
   output ttoi_pkg::result_type         result,
   input  wire logic                    res_full
);

   localparam int MAG_W  = ttoi_pkg::AMP_W;
   localparam int PROD_W = MAG_W + ttoi_pkg::TIME_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int CNT_W  = $clog2(PROD_W + 1);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type                     state_ff;
   ttoi_pkg::job_kind_type        kind_ff;
   logic                          last_ff;
   logic [ttoi_pkg::STATUS_W-1:0] status_ff;
   logic [ttoi_pkg::TIME_W-1:0]   t0_ff;
   logic                          neg_ff;
   logic [MAG_W-1:0]              mag_num_ff;
   logic [MAG_W-1:0]              mag_den_ff;
   logic [ttoi_pkg::TIME_W-1:0]   mag_dt_ff;
   logic [PROD_W-1:0]             quot_ff;
   logic [MAG_W:0]                rem_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [ttoi_pkg::TIME_W-1:0]   held_rise_ff;
   logic [ttoi_pkg::TIME_W-1:0]   held_fall_ff;

   logic [ttoi_pkg::DAMP_W-1:0]   abs_num;
   logic [ttoi_pkg::DAMP_W-1:0]   abs_den;
   logic [ttoi_pkg::DTIME_W-1:0]  abs_dt;
   logic [MAG_W:0]                rem_shift;
   logic                          rem_ge;
   logic signed [SUM_W-1:0]       sum;
   logic [ttoi_pkg::TIME_W-1:0]   sat_time;

   assign abs_num = job.num[ttoi_pkg::DAMP_W-1] ? -job.num : job.num;
   assign abs_den = job.den[ttoi_pkg::DAMP_W-1] ? -job.den : job.den;
   assign abs_dt  = job.dt[ttoi_pkg::DTIME_W-1] ? -job.dt : job.dt;

   // restoring divide, one quotient bit per cycle
   assign rem_shift = {rem_ff[MAG_W-1:0], quot_ff[PROD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, mag_den_ff});

   always_comb begin
      if (neg_ff) begin
         sum = $signed(SUM_W'(t0_ff)) - $signed(SUM_W'(quot_ff));
      end else begin
         sum = $signed(SUM_W'(t0_ff)) + $signed(SUM_W'(quot_ff));
      end
      if (sum[SUM_W-1]) begin
         sat_time = '0;
      end else if (sum[SUM_W-2:ttoi_pkg::TIME_W] != '0) begin
         sat_time = ttoi_pkg::TIME_MAX;
      end else begin
         sat_time = sum[ttoi_pkg::TIME_W-1:0];
      end
   end

   assign job_pop       = (state_ff == ST_IDLE) && !job_empty;
   assign rise_fb.done  = (state_ff == ST_SUM) && (kind_ff == ttoi_pkg::JOB_RISE);
   assign rise_fb.value = sat_time;
   assign res_push      = (state_ff == ST_OUT) && !res_full;

   always_comb begin
      result.status    = status_ff;
      result.rise_time = (status_ff == ttoi_pkg::STATUS_NO_RISE) ? '0 : held_rise_ff;
      result.fall_time = (status_ff == ttoi_pkg::STATUS_FOUND) ? held_fall_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  kind_ff    <= job.kind;
                  last_ff    <= job.last;
                  status_ff  <= job.status;
                  t0_ff      <= job.t0;
                  neg_ff     <= job.num[ttoi_pkg::DAMP_W-1] ^ job.den[ttoi_pkg::DAMP_W-1] ^
                                job.dt[ttoi_pkg::DTIME_W-1];
                  mag_num_ff <= abs_num[MAG_W-1:0];
                  mag_den_ff <= abs_den[MAG_W-1:0];
                  mag_dt_ff  <= abs_dt[ttoi_pkg::TIME_W-1:0];
                  state_ff   <= (job.kind == ttoi_pkg::JOB_NONE) ? ST_OUT : ST_MUL;
               end
            end
            ST_MUL: begin
               quot_ff  <= PROD_W'(mag_num_ff * mag_dt_ff);
               rem_ff   <= '0;
               count_ff <= DIV_STEPS;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= rem_ge ? rem_shift - {1'b0, mag_den_ff} : rem_shift;
               quot_ff  <= {quot_ff[PROD_W-2:0], rem_ge};
               count_ff <= count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               if (kind_ff == ttoi_pkg::JOB_RISE) begin
                  held_rise_ff <= sat_time;
               end else begin
                  held_fall_ff <= sat_time;
               end
               state_ff <= last_ff ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
               if (!res_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: design/time_over_threshold_interp_unit.sv
// channel   direction  handshake            payload
// req       in         push / full          req_sample_time, req_sample_amplitude,
//                                           req_last_sample
// rsp       out        empty / pop          rsp_rise_time, rsp_fall_time, rsp_status
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// one sample per cycle while no interpolation is pending and the job queue has room.
// each crossing takes the divider through pop, multiply, 40 divide steps and
// sum; a sample waits while the rise time it must compare with is in flight.
// two-entry queues sit between front and divider and before the result ports.
// reset is synchronous and clears the waveform state and loads register defaults.
`default_nettype none

module time_over_threshold_interp_unit #(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ttoi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ttoi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [ttoi_pkg::TIME_W-1:0]         req_sample_time,
   input  wire logic signed [ttoi_pkg::AMP_W-1:0]   req_sample_amplitude,
   input  wire logic                                req_last_sample,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [ttoi_pkg::TIME_W-1:0]              rsp_rise_time,
   output logic [ttoi_pkg::TIME_W-1:0]              rsp_fall_time,
   output logic [ttoi_pkg::STATUS_W-1:0]            rsp_status
);

   localparam int JOB_W = $bits(ttoi_pkg::job_type);
   localparam int RES_W = $bits(ttoi_pkg::result_type);

   ttoi_pkg::job_type     job_wr;
   ttoi_pkg::job_type     job_rd;
   logic [JOB_W-1:0]      job_rd_bits;
   logic                  job_push;
   logic                  job_full;
   logic                  job_pop;
   logic                  job_empty;
   ttoi_pkg::rise_fb_type rise_fb;
   ttoi_pkg::result_type  res_wr;
   ttoi_pkg::result_type  res_rd;
   logic [RES_W-1:0]      res_rd_bits;
   logic                  res_push;
   logic                  res_full;

   ttoi_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .push                 (push),
      .full                 (full),
      .req_sample_time      (req_sample_time),
      .req_sample_amplitude (req_sample_amplitude),
      .req_last_sample      (req_last_sample),
      .job_push             (job_push),
      .job                  (job_wr),
      .job_full             (job_full),
      .rise_fb              (rise_fb)
   );

   ttoi_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_job_q (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (job_push),
      .wr_data    (job_wr),
      .fifo_full  (job_full),
      .rd_en      (job_pop),
      .rd_data    (job_rd_bits),
      .fifo_empty (job_empty)
   );

   assign job_rd = ttoi_pkg::job_type'(job_rd_bits);

   ttoi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_rd),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rise_fb   (rise_fb),
      .res_push  (res_push),
      .result    (res_wr),
      .res_full  (res_full)
   );

   ttoi_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_res_q (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (res_push),
      .wr_data    (res_wr),
      .fifo_full  (res_full),
      .rd_en      (pop),
      .rd_data    (res_rd_bits),
      .fifo_empty (empty)
   );

   assign res_rd        = ttoi_pkg::result_type'(res_rd_bits);
   assign rsp_rise_time = res_rd.rise_time;
   assign rsp_fall_time = res_rd.fall_time;
   assign rsp_status    = res_rd.status;

endmodule

`default_nettype wire
